@@ rtl/mmf_pkg.sv @@
// shared types and constants for the monitoring message framer
`timescale 1ns / 1ps

package mmf_pkg;

  // header layout
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned POS_W        = 3;
  localparam logic [POS_W-1:0] POS_VERSION = 3'd0;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 3'd1;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 3'd4;
  localparam logic [POS_W-1:0] POS_TYPE    = 3'(HEADER_BYTES - 1);

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned REM_W   = 24;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned MAXL_W  = 24;
  localparam int unsigned STAT_W  = 2;

  // header checks
  localparam logic [BYTE_W-1:0] REQUIRED_VERSION = 8'd3;
  localparam logic [BYTE_W-1:0] LAST_KNOWN_TYPE  = 8'd5;
  localparam logic [MAXL_W-1:0] MAX_LEN_RESET    = 24'd65535;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LENGTH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_TYPE    = 2'd3;

  // framing phase
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_CLOSED = 3'b100
  } phase_t;

  // one result from the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] mtype;
    logic [LEN_W-1:0]  mlen;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

@@ rtl/monitoring_message_framer.sv @@
// monitoring message framer top level: input stage, parser, result register
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   in_      | slave     | tdata: stream_byte
//   out_     | master    | tdata: message_type, message_length, message_count
//            |           | tuser: status
//   cfg_     | write     | max_message_length, 24 bits
//
// one byte per cycle sustained unless a byte's result must wait on a full output register:
// a byte goes through the input register, the parser updates its state and at most one
// result lands in the output register, which drives out_.
// rst_n is synchronous; the byte limit returns to 65535 and framing restarts.
// a stalled result holds only bytes that would produce another result;
// bytes that produce nothing keep flowing while the result waits.
`timescale 1ns / 1ps

module monitoring_message_framer
  import mmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] stream_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,   // [7:0] message_type, [39:8] message_length,
                                         // [71:40] message_count
  output logic [1:0]        out_tuser,   // [1:0] status
  input  logic              cfg_wr_en,
  input  logic [MAXL_W-1:0] cfg_wr_data
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic [MAXL_W-1:0] max_len_r;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           res;
  logic              out_free;
  logic              step;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // parser
  mmf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .stream_byte (in_byte_r),
    .max_len     (max_len_r),
    .result      (res)
  );

  // stage advances unless its result finds the output register occupied
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && (!res.valid || out_free);
  assign in_tready = !in_valid_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.count, out_res_r.mlen, out_res_r.mtype};
  assign out_tuser  = out_res_r.status;

endmodule

@@ rtl/mmf_parser.sv @@
// header collection, body counting and message checks
`timescale 1ns / 1ps

module mmf_parser
  import mmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] stream_byte,
  input  logic [MAXL_W-1:0] max_len,
  output result_t           result
);

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] version_r, version_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [REM_W-1:0]  rem_init;
  logic [REM_W-1:0]  rem_dec;
  logic              len_bad;
  logic              finish;

  assign rem_init = REM_W'(len_r - LEN_W'(HEADER_BYTES));
  assign rem_dec  = rem_r - REM_W'(1);
  assign len_bad  = (len_r < LEN_W'(HEADER_BYTES)) ||
                    (len_r > {{(LEN_W-MAXL_W){1'b0}}, max_len});

  // next state and result for the byte in hand
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    version_nxt   = version_r;
    type_nxt      = type_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    finish        = 1'b0;
    result        = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r == POS_TYPE) begin
          type_nxt = stream_byte;
          pos_nxt  = '0;
          if (len_bad) begin
            phase_nxt     = PH_CLOSED;
            result.valid  = 1'b1;
            result.status = ST_BAD_LENGTH;
          end else if (rem_init == '0) begin
            finish = 1'b1;
          end else begin
            rem_nxt   = rem_init;
            phase_nxt = PH_BODY;
          end
        end else begin
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r == POS_VERSION) begin
            version_nxt = stream_byte;
            len_nxt     = '0;
          end else if (pos_r >= POS_LEN_LO && pos_r <= POS_LEN_HI) begin
            len_nxt = {len_r[LEN_W-BYTE_W-1:0], stream_byte};
          end
        end
      end
      PH_BODY: begin
        rem_nxt = rem_dec;
        finish  = (rem_dec == '0);
      end
      default: begin
      end
    endcase

    // message complete: version, count, type
    if (finish) begin
      result.valid = 1'b1;
      if (version_r != REQUIRED_VERSION) begin
        phase_nxt     = PH_CLOSED;
        result.status = ST_BAD_VERSION;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (type_nxt > LAST_KNOWN_TYPE) begin
          phase_nxt     = PH_CLOSED;
          result.status = ST_BAD_TYPE;
        end else begin
          phase_nxt     = PH_HEADER;
          pos_nxt       = '0;
          rem_nxt       = '0;
          result.status = ST_OK;
        end
      end
    end

    result.mtype = type_nxt;
    result.mlen  = len_r;
    result.count = cnt_nxt;
  end

  // state update on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      version_r <= '0;
      type_r    <= '0;
      len_r     <= '0;
      rem_r     <= '0;
      cnt_r     <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      version_r <= version_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      rem_r     <= rem_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule
